/* src/peu_pkg.sv */
// ----------------------------------------------------------------------------
// peu_pkg
// Types, constants and helpers shared by the particle Euler update block.
// ----------------------------------------------------------------------------
package peu_pkg;

   localparam int STEP_W    = 17;
   localparam int FRAC_W    = 16;
   localparam int DIV_STEPS = 16;

   localparam logic [STEP_W-1:0] STEP_RESET = 17'd1092;
   localparam logic [STEP_W-1:0] Q_ONE      = 17'h10000;

   localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] SAT_MIN = 34'sh3_8000_0000;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] life_left;
      logic        [30:0] life_total;
      logic signed [31:0] angle;
      logic signed [31:0] spin_rate;
      logic signed [31:0] size_begin;
      logic signed [31:0] size_finish;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_life;
      logic signed [31:0] new_angle;
      logic signed [31:0] current_size;
      logic               alive;
   } rsp_type;

   // particle state carried down the pipeline
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] angle;
      logic signed [31:0] life;
      logic signed [31:0] size_begin;
      logic signed [31:0] size_finish;
      logic               alive;
      logic               ratio_one;
   } part_type;

   // clamp a 34-bit signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* src/particle_euler_update_unit.sv */
// Pipeline: 19 register stages, from the request register to the output
// register that drives rsp_valid.
// Throughput: one transaction per cycle while no response stall holds it; the
// 16 stages of the radix-2 divider for the life ratio set the pipeline depth.
// A response stall freezes the whole pipeline and stalls the request side.
// Synchronous reset clears all valid bits and loads step_ff with 1092.
// ----------------------------------------------------------------------------
// particle_euler_update_unit
// Semi-implicit Euler step of one particle record per transaction, Q16.16,
// with saturating sums and size interpolation over the remaining life.
// ----------------------------------------------------------------------------
module particle_euler_update_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [peu_pkg::STEP_W-1:0]      csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  peu_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output peu_pkg::rsp_type                rsp_data
);

   localparam int NST = peu_pkg::DIV_STEPS + 3;

   logic [peu_pkg::STEP_W-1:0] step_ff;
   logic                       en;
   logic [NST:1]               v_ff;
   logic [NST:1]               v_in;

   // stage 1: input register plus new life
   peu_pkg::req_type   s1_ff;
   logic signed [31:0] s1_nl_ff;
   logic               s1_alive_ff;
   logic signed [31:0] s1_nl_in;
   logic               s1_alive_in;

   // main carry line, stages 2..17
   peu_pkg::part_type  pipe_ff [2:17];
   peu_pkg::part_type  pipe_in [2:17];

   // step products
   logic signed [33:0] pa_x_ff, pa_y_ff, pspin_ff, pv_x_ff, pv_y_ff;
   logic signed [33:0] pa_x_in, pa_y_in, pspin_in, pv_x_in, pv_y_in;

   // divider
   logic [31:0]                    div_rem_ff   [1:peu_pkg::DIV_STEPS];
   logic [peu_pkg::DIV_STEPS-1:0]  div_q_ff     [1:peu_pkg::DIV_STEPS];
   logic [30:0]                    div_total_ff [1:peu_pkg::DIV_STEPS];
   logic [31:0]                    div_rem_in   [1:peu_pkg::DIV_STEPS];
   logic [peu_pkg::DIV_STEPS-1:0]  div_q_in     [1:peu_pkg::DIV_STEPS];
   logic [30:0]                    div_total_in [1:peu_pkg::DIV_STEPS];

   // stage 18 and output
   peu_pkg::part_type  s18_ff;
   logic signed [33:0] size_prod_ff;
   logic signed [33:0] size_prod_in;
   peu_pkg::rsp_type   rsp_ff;
   peu_pkg::rsp_type   rsp_in;

   assign en        = !(v_ff[NST] && rsp_stall);
   assign req_stall = v_ff[NST] && rsp_stall;
   assign rsp_valid = v_ff[NST];
   assign rsp_data  = rsp_ff;

   assign v_in = {v_ff[NST-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= peu_pkg::STEP_RESET;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // stage 1
   always_comb begin
      logic signed [32:0] diff;
      diff = {req_data.life_left[31], req_data.life_left}
           - $signed({16'b0, step_ff});
      s1_nl_in    = peu_pkg::sat32({diff[32], diff});
      s1_alive_in = (s1_nl_in > 32'sd0);
   end

   // stage 2: acceleration and spin products
   always_comb begin
      logic signed [49:0] p_ax, p_ay, p_sp;
      p_ax = s1_ff.acc_x * $signed({1'b0, step_ff});
      p_ay = s1_ff.acc_y * $signed({1'b0, step_ff});
      p_sp = s1_ff.spin_rate * $signed({1'b0, step_ff});
      pa_x_in  = p_ax[49:16];
      pa_y_in  = p_ay[49:16];
      pspin_in = p_sp[49:16];
   end

   // stage 4: products of the new velocity
   always_comb begin
      logic signed [49:0] p_vx, p_vy;
      p_vx = pipe_ff[3].vel_x * $signed({1'b0, step_ff});
      p_vy = pipe_ff[3].vel_y * $signed({1'b0, step_ff});
      pv_x_in = p_vx[49:16];
      pv_y_in = p_vy[49:16];
   end

   // carry line: stage 2 loads the record and the ratio bypass flag, stage 3
   // updates velocity and angle, stage 5 position, stages 6..17 wait for the
   // divider
   always_comb begin
      pipe_in[2].pos_x       = s1_ff.pos_x;
      pipe_in[2].pos_y       = s1_ff.pos_y;
      pipe_in[2].vel_x       = s1_ff.vel_x;
      pipe_in[2].vel_y       = s1_ff.vel_y;
      pipe_in[2].angle       = s1_ff.angle;
      pipe_in[2].life        = s1_nl_ff;
      pipe_in[2].size_begin  = s1_ff.size_begin;
      pipe_in[2].size_finish = s1_ff.size_finish;
      pipe_in[2].alive       = s1_alive_ff;
      pipe_in[2].ratio_one   = (s1_ff.life_total == 31'd0) ||
         ({s1_nl_ff[31], s1_nl_ff} >= $signed({2'b0, s1_ff.life_total}));

      pipe_in[3] = pipe_ff[2];
      if (pipe_ff[2].alive) begin
         pipe_in[3].vel_x = peu_pkg::sat32(
            {{2{pipe_ff[2].vel_x[31]}}, pipe_ff[2].vel_x} + pa_x_ff);
         pipe_in[3].vel_y = peu_pkg::sat32(
            {{2{pipe_ff[2].vel_y[31]}}, pipe_ff[2].vel_y} + pa_y_ff);
         pipe_in[3].angle = peu_pkg::sat32(
            {{2{pipe_ff[2].angle[31]}}, pipe_ff[2].angle} + pspin_ff);
      end

      pipe_in[4] = pipe_ff[3];

      pipe_in[5] = pipe_ff[4];
      if (pipe_ff[4].alive) begin
         pipe_in[5].pos_x = peu_pkg::sat32(
            {{2{pipe_ff[4].pos_x[31]}}, pipe_ff[4].pos_x} + pv_x_ff);
         pipe_in[5].pos_y = peu_pkg::sat32(
            {{2{pipe_ff[4].pos_y[31]}}, pipe_ff[4].pos_y} + pv_y_ff);
      end

      for (int k = 6; k <= 17; k++) begin
         pipe_in[k] = pipe_ff[k-1];
      end
   end

   // restoring divider, one quotient bit per stage: nl * 2^16 / total
   always_comb begin
      logic [31:0] rem_prev;
      logic [peu_pkg::DIV_STEPS-1:0] q_prev;
      logic [30:0] tot_prev;
      logic [33:0] trial;
      for (int k = 1; k <= peu_pkg::DIV_STEPS; k++) begin
         if (k == 1) begin
            rem_prev = s1_nl_ff;
            q_prev   = '0;
            tot_prev = s1_ff.life_total;
         end else begin
            rem_prev = div_rem_ff[k-1];
            q_prev   = div_q_ff[k-1];
            tot_prev = div_total_ff[k-1];
         end
         trial = {1'b0, rem_prev, 1'b0} - {3'b0, tot_prev};
         if (!trial[33]) begin
            div_rem_in[k] = trial[31:0];
            div_q_in[k]   = {q_prev[peu_pkg::DIV_STEPS-2:0], 1'b1};
         end else begin
            div_rem_in[k] = {rem_prev[30:0], 1'b0};
            div_q_in[k]   = {q_prev[peu_pkg::DIV_STEPS-2:0], 1'b0};
         end
         div_total_in[k] = tot_prev;
      end
   end

   // stage 18: size product
   always_comb begin
      logic [peu_pkg::STEP_W-1:0] ratio;
      logic signed [32:0] size_diff;
      logic signed [50:0] p_sz;
      ratio = pipe_ff[17].ratio_one ? peu_pkg::Q_ONE
                                    : {1'b0, div_q_ff[peu_pkg::DIV_STEPS]};
      size_diff = {pipe_ff[17].size_begin[31], pipe_ff[17].size_begin}
                - {pipe_ff[17].size_finish[31], pipe_ff[17].size_finish};
      p_sz = size_diff * $signed({1'b0, ratio});
      size_prod_in = p_sz[49:16];
   end

   // stage 19: output register
   always_comb begin
      rsp_in.new_pos_x = s18_ff.pos_x;
      rsp_in.new_pos_y = s18_ff.pos_y;
      rsp_in.new_vel_x = s18_ff.vel_x;
      rsp_in.new_vel_y = s18_ff.vel_y;
      rsp_in.new_life  = s18_ff.life;
      rsp_in.new_angle = s18_ff.angle;
      rsp_in.alive     = s18_ff.alive;
      if (s18_ff.alive) begin
         rsp_in.current_size = peu_pkg::sat32(
            {{2{s18_ff.size_finish[31]}}, s18_ff.size_finish} + size_prod_ff);
      end else begin
         rsp_in.current_size = s18_ff.size_finish;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff        <= req_data;
         s1_nl_ff     <= s1_nl_in;
         s1_alive_ff  <= s1_alive_in;
         pa_x_ff      <= pa_x_in;
         pa_y_ff      <= pa_y_in;
         pspin_ff     <= pspin_in;
         pv_x_ff      <= pv_x_in;
         pv_y_ff      <= pv_y_in;
         for (int k = 2; k <= 17; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         for (int k = 1; k <= peu_pkg::DIV_STEPS; k++) begin
            div_rem_ff[k]   <= div_rem_in[k];
            div_q_ff[k]     <= div_q_in[k];
            div_total_ff[k] <= div_total_in[k];
         end
         s18_ff       <= pipe_ff[17];
         size_prod_ff <= size_prod_in;
         rsp_ff       <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // survivor flag must agree with the life it reports
   a_alive_life: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.alive == (rsp_data.new_life > 32'sd0)))
      else $error("alive flag disagrees with new_life");

   // a divided ratio leaves a remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (v_ff[17] && pipe_ff[17].alive && !pipe_ff[17].ratio_one) |->
      (div_rem_ff[peu_pkg::DIV_STEPS] < {1'b0, div_total_ff[peu_pkg::DIV_STEPS]}))
      else $error("divider remainder not below total");

   // reset empties the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> (v_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule

/* tb/particle_euler_update_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_euler_update_unit_tb
// Streams particle records through the Euler update unit under random request
// gaps and response stalls, over a series of frame steps from zero up to the
// register maximum. Each response is checked field by field against a
// fixed-point predictor of the semi-implicit step.
// ----------------------------------------------------------------------------
module particle_euler_update_unit_tb;

   typedef logic [peu_pkg::STEP_W-1:0] step_type;

   localparam int     RAND_PER_PHASE = 180;
   localparam int     NUM_PHASES     = 8;
   localparam int     IDLE_LIMIT     = 2000;
   localparam int     SETTLE_CYCLES  = 30;
   localparam longint Q_UNIT         = 65536;

   localparam logic signed [31:0] RAIL_VALUES [7] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'sh0000_0001,
      32'shFFFF_FFFF, 32'sh0001_0000, 32'shFFFF_0000
   };

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   step_type          csr_wr_data = '0;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   peu_pkg::req_type  req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   peu_pkg::rsp_type  rsp_data;

   peu_pkg::req_type  particle_feed[$];
   peu_pkg::rsp_type  advanced_particles[$];
   step_type          unit_step;
   logic              req_taken   = 1'b0;
   logic              rsp_taken   = 1'b0;
   int                fault_count = 0;
   int                idle_cycles = 0;
   int                send_gap    = 0;
   bit                send_burst  = 1'b0;
   int                hold_left   = 0;
   bit                recv_burst  = 1'b0;

   particle_euler_update_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // exact product, low 16 fraction bits dropped toward minus infinity
   function automatic longint scale_q(input longint a, input longint s);
      return (a * s) >>> 16;
   endfunction

   function automatic peu_pkg::rsp_type advance_particle(input peu_pkg::req_type p,
                                                         input step_type step);
      peu_pkg::rsp_type r;
      longint  s;
      longint  life;
      longint  total;
      longint  vx;
      longint  vy;
      longint  ratio;
      s     = longint'(step);
      life  = clamp32(longint'(p.life_left) - s);
      total = longint'(p.life_total);
      r.new_life = life[31:0];
      r.alive    = (life > 0);
      if (life > 0) begin
         vx = clamp32(longint'(p.vel_x) + scale_q(p.acc_x, s));
         vy = clamp32(longint'(p.vel_y) + scale_q(p.acc_y, s));
         r.new_vel_x = vx[31:0];
         r.new_vel_y = vy[31:0];
         r.new_pos_x = clamp32(longint'(p.pos_x) + scale_q(vx, s));
         r.new_pos_y = clamp32(longint'(p.pos_y) + scale_q(vy, s));
         r.new_angle = clamp32(longint'(p.angle) + scale_q(p.spin_rate, s));
         if (total == 0 || life >= total) begin
            ratio = Q_UNIT;
         end else begin
            ratio = (life * Q_UNIT) / total;
            if (ratio > Q_UNIT) ratio = Q_UNIT;
         end
         r.current_size = clamp32(longint'(p.size_finish) +
            scale_q(longint'(p.size_begin) - longint'(p.size_finish), ratio));
      end else begin
         r.new_pos_x    = p.pos_x;
         r.new_pos_y    = p.pos_y;
         r.new_vel_x    = p.vel_x;
         r.new_vel_y    = p.vel_y;
         r.new_angle    = p.angle;
         r.current_size = p.size_finish;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic signed [31:0] q_value();
      case ($urandom_range(0, 9))
         0: return RAIL_VALUES[$urandom_range(0, 6)];
         1, 2, 3: return $urandom();
         default: return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      endcase
   endfunction

   function automatic logic signed [31:0] life_value(input longint step);
      int base;
      base = int'(step);
      case ($urandom_range(0, 9))
         0: return q_value();
         1: return base - int'($urandom_range(0, 2));   // expires this frame
         2: return base + int'($urandom_range(1, 2));   // barely survives
         3: return -int'($urandom_range(0, 32'h0010_0000));
         default: return base + int'($urandom_range(1, 32'h0040_0000));
      endcase
   endfunction

   function automatic logic [30:0] total_value(input logic signed [31:0] life);
      longint t;
      case ($urandom_range(0, 9))
         0: t = 0;
         1: t = 64'h7FFF_FFFF;
         2: t = $urandom_range(0, 32'h7FFF_FFFF);
         3: t = longint'(life) / 2;   // life outlasts total
         default: t = longint'(life) + longint'($urandom_range(0, 32'h0040_0000));
      endcase
      if (t < 0 || t > 64'h7FFF_FFFF) t = $urandom_range(1, 32'h7FFF_FFFF);
      return t[30:0];
   endfunction

   function automatic peu_pkg::req_type random_particle(input longint step);
      peu_pkg::req_type p;
      bit      noise;
      noise         = ($urandom_range(0, 6) == 0);
      p.pos_x       = q_value();
      p.pos_y       = q_value();
      p.vel_x       = q_value();
      p.vel_y       = q_value();
      p.acc_x       = q_value();
      p.acc_y       = q_value();
      p.angle       = q_value();
      p.spin_rate   = q_value();
      p.size_begin  = q_value();
      p.size_finish = q_value();
      p.life_left   = noise ? $urandom() : life_value(step);
      p.life_total  = noise ? 31'($urandom()) : total_value(p.life_left);
      return p;
   endfunction

   task automatic queue_particle(input peu_pkg::req_type p);
      particle_feed = {particle_feed, p};
   endtask

   task automatic load_directed(input longint step);
      peu_pkg::req_type p;
      peu_pkg::req_type base;
      base             = '0;
      base.life_total  = 31'h0010_0000;
      base.size_begin  = 32'sh0004_0000;
      base.size_finish = 32'sh0001_0000;
      // no life left: record passes through dead
      p = base;
      p.pos_x = 32'sh0012_3456;
      p.vel_y = -32'sh0000_8000;
      p.angle = 32'sh005A_0000;
      queue_particle(p);
      // life ends exactly on this frame
      p = base;
      p.life_left = 32'(step);
      p.vel_x     = 32'sh0001_0000;
      queue_particle(p);
      // one LSB of life survives
      p = base;
      p.life_left = 32'(step + 1);
      p.acc_x     = 32'sh0003_0000;
      p.spin_rate = 32'sh0168_0000;
      queue_particle(p);
      // most negative life, difference saturates low
      p = base;
      p.life_left   = 32'sh8000_0000;
      p.size_finish = 32'sh8000_0000;
      queue_particle(p);
      // zero total life, ratio taken as one
      p = base;
      p.life_left  = 32'sh7FFF_FFFF;
      p.life_total = '0;
      queue_particle(p);
      // life above total, ratio clamps to one
      p = base;
      p.life_left  = 32'sh0020_0000;
      p.life_total = 31'h0000_0001;
      queue_particle(p);
      // top of range everywhere, sums saturate high
      p = base;
      p.life_left   = 32'sh0008_0000;
      p.pos_x       = 32'sh7FFF_FFFF;
      p.pos_y       = 32'sh7FFF_FFFF;
      p.vel_x       = 32'sh7FFF_FFFF;
      p.vel_y       = 32'sh7FFF_FFFF;
      p.acc_x       = 32'sh7FFF_FFFF;
      p.acc_y       = 32'sh7FFF_FFFF;
      p.angle       = 32'sh7FFF_FFFF;
      p.spin_rate   = 32'sh7FFF_FFFF;
      p.size_begin  = 32'sh7FFF_FFFF;
      p.size_finish = 32'sh8000_0000;
      queue_particle(p);
      // bottom of range everywhere
      p = base;
      p.life_left   = 32'sh0008_0000;
      p.pos_x       = 32'sh8000_0000;
      p.pos_y       = 32'sh8000_0000;
      p.vel_x       = 32'sh8000_0000;
      p.vel_y       = 32'sh8000_0000;
      p.acc_x       = 32'sh8000_0000;
      p.acc_y       = 32'sh8000_0000;
      p.angle       = 32'sh8000_0000;
      p.spin_rate   = 32'sh8000_0000;
      p.size_begin  = 32'sh8000_0000;
      p.size_finish = 32'sh7FFF_FFFF;
      queue_particle(p);
      // widest total life
      p = base;
      p.life_left  = 32'sh4000_0000;
      p.life_total = 31'h7FFF_FFFF;
      queue_particle(p);
      // tiny negative products round toward minus infinity
      p = base;
      p.life_left = 32'sh0001_0000 + 32'(step);
      p.acc_x     = -32'sh0000_0001;
      p.acc_y     = 32'sh0000_0001;
      p.vel_x     = -32'sh0000_0003;
      p.spin_rate = -32'sh0000_0001;
      queue_particle(p);
      // halfway through life, negative size at birth
      p = base;
      p.life_left   = 32'sh0008_0000 + 32'(step);
      p.size_begin  = -32'sh0010_0000;
      p.size_finish = 32'sh0003_0000;
      queue_particle(p);
      // dead with extreme kinematics, all pass through
      p = base;
      p.life_left   = -32'sh0000_0001;
      p.pos_x       = 32'sh7FFF_FFFF;
      p.pos_y       = 32'sh8000_0000;
      p.vel_x       = 32'sh8000_0000;
      p.vel_y       = 32'sh7FFF_FFFF;
      p.acc_x       = 32'sh7FFF_FFFF;
      p.angle       = 32'sh8000_0000;
      p.spin_rate   = 32'sh7FFF_FFFF;
      p.size_finish = 32'sh8000_0000;
      queue_particle(p);
   endtask

   task automatic await_quiet();
      do @(posedge clock);
      while (particle_feed.size() != 0 || req_valid || advanced_particles.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endtask

   // ---------------------------------------------------------------- request driver

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (particle_feed.size() > 0) begin
            req_data  <= particle_feed.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- response stall

   always @(negedge clock) begin
      if (rsp_taken) begin
         if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
         hold_left = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (reset || hold_left == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      peu_pkg::rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (reset) begin
         unit_step   = peu_pkg::STEP_RESET;
         idle_cycles = 0;
      end else begin
         if (req_valid && !req_stall) begin
            advanced_particles = {advanced_particles,
                                  advance_particle(req_data, unit_step)};
         end
         if (rsp_valid && !rsp_stall) begin
            if (advanced_particles.size() == 0) begin
               $error("response transaction with nothing outstanding");
               fault_count++;
            end else begin
               want = advanced_particles.pop_front();
               compare_field("new_pos_x", want.new_pos_x, rsp_data.new_pos_x);
               compare_field("new_pos_y", want.new_pos_y, rsp_data.new_pos_y);
               compare_field("new_vel_x", want.new_vel_x, rsp_data.new_vel_x);
               compare_field("new_vel_y", want.new_vel_y, rsp_data.new_vel_y);
               compare_field("new_life", want.new_life, rsp_data.new_life);
               compare_field("new_angle", want.new_angle, rsp_data.new_angle);
               compare_field("current_size", want.current_size, rsp_data.current_size);
               compare_field("alive", {31'b0, want.alive}, {31'b0, rsp_data.alive});
            end
         end
         // writes only land while idle, so ordering against requests is moot
         if (csr_wr_en) unit_step = csr_wr_data;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $error("no transaction for %0d cycles, %0d responses outstanding",
                   idle_cycles, advanced_particles.size());
            $display("particle_euler_update_unit_tb: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      step_type phase_steps[NUM_PHASES];
      step_type cur_step;
      phase_steps[0] = peu_pkg::STEP_RESET;   // left at its reset value
      phase_steps[1] = '0;
      phase_steps[2] = 17'h1_0000;
      phase_steps[3] = 17'h1_FFFF;
      phase_steps[4] = 17'd1;
      phase_steps[5] = step_type'($urandom_range(0, 32'h1_0000));
      phase_steps[6] = step_type'($urandom_range(0, 32'h1_FFFF));
      phase_steps[7] = peu_pkg::STEP_RESET;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      cur_step = peu_pkg::STEP_RESET;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 0) begin
            load_directed(cur_step);
         end else begin
            await_quiet();
            cur_step = phase_steps[ph];
            @(negedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= cur_step;
            @(negedge clock);
            csr_wr_en <= 1'b0;
            @(posedge clock);
         end
         for (int i = 0; i < RAND_PER_PHASE; i++) begin
            // hold the sender off once until the pipeline has fully drained
            if (ph == 3 && i == RAND_PER_PHASE / 2) await_quiet();
            queue_particle(random_particle(cur_step));
         end
      end
      await_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("particle_euler_update_unit_tb: clean");
      end else begin
         $display("particle_euler_update_unit_tb: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/peu_pkg.sv
src/particle_euler_update_unit.sv
tb/particle_euler_update_unit_tb.sv
